// File: hw/rtl/ubfp_pkg.sv
package ubfp_pkg;

	// Characters the matchers look for.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_F      = 8'h46;
	localparam logic [7:0] CH_W      = 8'h57;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_V      = 8'h56;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// Command register codes.
	localparam logic [7:0] CMD_NONE   = 8'hFF;
	localparam logic [7:0] CMD_HEADER = 8'h00;
	localparam logic [7:0] CMD_FW     = 8'h01;
	localparam logic [7:0] CMD_PAGE   = 8'h02;

	// Header is five bytes; the length field at most four characters.
	localparam logic [2:0] HDR_BYTES   = 3'd5;
	localparam logic [2:0] LEN_CHARS   = 3'd4;
	localparam logic [1:0] LEAD_SKIP   = 2'd3;
	localparam logic [3:0] RECV_FULL   = 4'd11;
	localparam int         LVAL_W      = 14;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 88;

	// One result word.
	typedef struct packed {
		logic [7:0]  command_code;
		logic        command_set;
		logic        header_done;
		logic [7:0]  page_index;
		logic [31:0] page_crc;
		logic        prompt_seen;
		logic        data_valid;
		logic [9:0]  data_index;
		logic [7:0]  data_value;
		logic        page_done;
		logic [10:0] page_length;
	} ubfp_res_t;

	// One step of the "+RECEIVE,1," matcher.
	function automatic logic [3:0] step_receive(input logic [3:0] m, input logic [7:0] b);
		logic [3:0] r;
		r = 4'd0;
		case (b)
			CH_PLUS:  r = m + 4'd1;
			CH_R:     r = (m == 4'd1) ? 4'd2 : 4'd0;
			CH_E:     r = (m == 4'd2 || m == 4'd4 || m == 4'd7) ? m + 4'd1 : 4'd0;
			CH_C:     r = (m == 4'd3) ? 4'd4 : 4'd0;
			CH_I:     r = (m == 4'd5) ? 4'd6 : 4'd0;
			CH_V:     r = (m == 4'd6) ? 4'd7 : 4'd0;
			CH_COMMA: r = (m == 4'd8 || m == 4'd10) ? m + 4'd1 : 4'd0;
			CH_ONE:   r = (m == 4'd9) ? 4'd10 : 4'd0;
			default:  r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/ubfp_parser.sv
module ubfp_parser #(
	parameter int PAGE_SIZE = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	input  logic                 program_phase,
	output ubfp_pkg::ubfp_res_t  res
);
	import ubfp_pkg::*;

	localparam int PTR_W = $clog2(PAGE_SIZE + 1);
	localparam logic [PTR_W-1:0] PAGE_LIM = PTR_W'(PAGE_SIZE);

	// Parser state.
	logic [1:0]       fw_q, cm_q, pm_q, lead_q;
	logic [7:0]       cmd_q;
	logic [2:0]       hcnt_q, dcnt_q;
	logic [7:0]       hdr_q [5];
	logic [3:0]       rm_q;
	logic             lact_q, lminus_q, lstop_q;
	logic [LVAL_W-1:0] lval_q;
	logic [PTR_W-1:0] exp_q, wp_q;

	logic [1:0]       fw_n, cm_n, pm_n, lead_n;
	logic [7:0]       cmd_n;
	logic [2:0]       hcnt_n, dcnt_n, hidx;
	logic [7:0]       hdr_n [5];
	logic [3:0]       rm_n;
	logic             lact_n, lminus_n, lstop_n;
	logic [LVAL_W-1:0] lval_n;
	logic [PTR_W-1:0] exp_n, wp_n;

	logic             cset, hdone, prompt, dv, pdone;
	logic [PTR_W-1:0] di, plen;
	logic [7:0]       dval;
	logic [PTR_W+10:0] di_ext, plen_ext;

	// Run all matchers on the current byte in their fixed order.
	always_comb begin
		fw_n = fw_q;
		cm_n = cm_q;
		pm_n = pm_q;
		lead_n = lead_q;
		cmd_n = cmd_q;
		hcnt_n = hcnt_q;
		dcnt_n = dcnt_q;
		hdr_n = hdr_q;
		rm_n = rm_q;
		lact_n = lact_q;
		lminus_n = lminus_q;
		lstop_n = lstop_q;
		lval_n = lval_q;
		exp_n = exp_q;
		wp_n = wp_q;
		hidx = 3'd0;
		cset = 1'b0;
		hdone = 1'b0;
		prompt = 1'b0;
		dv = 1'b0;
		pdone = 1'b0;
		di = '0;
		plen = '0;
		dval = 8'd0;

		// "$FW" matcher.
		case (rx_byte)
			CH_DOLLAR: fw_n = fw_q + 2'd1;
			CH_F:      fw_n = (fw_q == 2'd1) ? 2'd2 : 2'd0;
			CH_W:      fw_n = (fw_q == 2'd2) ? 2'd3 : 2'd0;
			default:   fw_n = 2'd0;
		endcase
		if (fw_n == 2'd3) begin
			cmd_n = CMD_FW;
			cset = 1'b1;
			fw_n = 2'd0;
		end

		// Header capture while the command is zero.
		if (cmd_n == CMD_HEADER) begin
			hidx = (hcnt_q > 3'd4) ? 3'd0 : hcnt_q;
			for (int i = 0; i < 5; i++) begin
				if (hidx == 3'(i)) hdr_n[i] = rx_byte;
			end
			hcnt_n = hidx + 3'd1;
			if (hcnt_n == HDR_BYTES) begin
				cmd_n = CMD_PAGE;
				cset = 1'b1;
				hdone = 1'b1;
				hcnt_n = 3'd0;
			end
		end

		// "$C" then the command byte.
		if (cm_q == 2'd2) begin
			cmd_n = rx_byte;
			cset = 1'b1;
		end
		case (rx_byte)
			CH_DOLLAR: cm_n = ((cm_q == 2'd2) ? 2'd0 : cm_q) + 2'd1;
			CH_C:      cm_n = (cm_q == 2'd1) ? 2'd2 : 2'd0;
			default:   cm_n = 2'd0;
		endcase

		// "> " prompt.
		case (rx_byte)
			CH_GT:    pm_n = pm_q + 2'd1;
			CH_SPACE: pm_n = (pm_q == 2'd1) ? 2'd2 : 2'd0;
			default:  pm_n = 2'd0;
		endcase
		if (pm_n >= 2'd2) begin
			prompt = 1'b1;
			pm_n = 2'd0;
		end

		// Length field: digits accumulate as they arrive.
		if (lact_q) begin
			if (rx_byte != CH_COLON && dcnt_q < LEN_CHARS) begin
				if (dcnt_q == 3'd0 && rx_byte == CH_MINUS) lminus_n = 1'b1;
				if (!lstop_q) begin
					if (rx_byte == CH_NUL) begin
						lstop_n = 1'b1;
					end else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
						lval_n = (lval_q << 3) + (lval_q << 1)
							+ LVAL_W'(rx_byte - CH_ZERO);
					end
				end
				dcnt_n = dcnt_q + 3'd1;
			end else begin
				exp_n = (lminus_q || lval_q > LVAL_W'(PAGE_SIZE)) ? '0 : lval_q[PTR_W-1:0];
				lact_n = 1'b0;
				dcnt_n = 3'd0;
				lval_n = '0;
				lminus_n = 1'b0;
				lstop_n = 1'b0;
			end
		end

		// Page data: skip the lead bytes, then write into the page.
		if (exp_n != '0) begin
			if (lead_q >= LEAD_SKIP) begin
				if (wp_q < PAGE_LIM) begin
					dv = 1'b1;
					di = wp_q;
					dval = rx_byte;
					wp_n = wp_q + PTR_W'(1);
				end
			end else begin
				lead_n = lead_q + 2'd1;
			end
			if (wp_n == exp_n) begin
				pdone = 1'b1;
				plen = wp_n;
				exp_n = '0;
				wp_n = '0;
				lead_n = 2'd0;
			end
		end

		// "+RECEIVE,1," opens a length field, only in program phase.
		if (program_phase) begin
			rm_n = step_receive(rm_q, rx_byte);
			if (rm_n >= RECV_FULL) begin
				lact_n = 1'b1;
				rm_n = 4'd0;
			end
		end
	end

	assign di_ext   = {11'd0, di};
	assign plen_ext = {11'd0, plen};

	// Result word for this byte.
	always_comb begin
		res.command_code = cmd_n;
		res.command_set  = cset;
		res.header_done  = hdone;
		res.page_index   = hdr_n[0];
		res.page_crc     = {hdr_n[4], hdr_n[3], hdr_n[2], hdr_n[1]};
		res.prompt_seen  = prompt;
		res.data_valid   = dv;
		res.data_index   = di_ext[9:0];
		res.data_value   = dval;
		res.page_done    = pdone;
		res.page_length  = plen_ext[10:0];
	end

	// State registers advance once per byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 2'd0;
			cm_q <= 2'd0;
			pm_q <= 2'd0;
			lead_q <= 2'd0;
			cmd_q <= CMD_NONE;
			hcnt_q <= 3'd0;
			dcnt_q <= 3'd0;
			for (int i = 0; i < 5; i++) hdr_q[i] <= 8'd0;
			rm_q <= 4'd0;
			lact_q <= 1'b0;
			lminus_q <= 1'b0;
			lstop_q <= 1'b0;
			lval_q <= '0;
			exp_q <= '0;
			wp_q <= '0;
		end else if (step) begin
			fw_q <= fw_n;
			cm_q <= cm_n;
			pm_q <= pm_n;
			lead_q <= lead_n;
			cmd_q <= cmd_n;
			hcnt_q <= hcnt_n;
			dcnt_q <= dcnt_n;
			hdr_q <= hdr_n;
			rm_q <= rm_n;
			lact_q <= lact_n;
			lminus_q <= lminus_n;
			lstop_q <= lstop_n;
			lval_q <= lval_n;
			exp_q <= exp_n;
			wp_q <= wp_n;
		end
	end

endmodule

// File: hw/rtl/uart_bootloader_frame_parser_unit.sv
// Channel   Dir  Fields (tdata, lowest bit first)
// s_axis    in   rx_byte[7:0], program_phase[8], zero pad to 16 bits
// m_axis    out  command_code, command_set, header_done, page_index, page_crc,
//                prompt_seen, data_valid, data_index, data_value, page_done,
//                page_length, zero pad to 88 bits
//
// One word in, one word out. A word lands in an input register, is parsed from
// there and its result is held in the output register; a new word is taken every
// cycle while the output drains.
// arst_n clears all matchers, the command register (to none) and the page state.
// A stall on m_tready holds the result and lets one more word wait at the input.
module uart_bootloader_frame_parser_unit #(
	parameter int PAGE_SIZE = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ubfp_pkg::IN_DATA_W-1:0]     s_tdata,  // rx_byte, program_phase
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ubfp_pkg::OUT_DATA_W-1:0]    m_tdata   // command_code, command_set,
	                                                     // header_done, page_index,
	                                                     // page_crc, prompt_seen,
	                                                     // data_valid, data_index,
	                                                     // data_value, page_done,
	                                                     // page_length
);
	import ubfp_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       phase_s1;
	logic       vld_q;
	ubfp_res_t  res_q;
	ubfp_res_t  res;
	logic       advance;

	// The parsed word moves on when the output register is free or draining.
	assign advance  = vld_s1 && (!vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata[7:0];
			phase_s1 <= s_tdata[8];
		end
	end

	ubfp_parser #(
		.PAGE_SIZE(PAGE_SIZE)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.rx_byte      (byte_s1),
		.program_phase(phase_s1),
		.res          (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {6'd0, res_q.page_length, res_q.page_done, res_q.data_value,
		res_q.data_index, res_q.data_valid, res_q.prompt_seen, res_q.page_crc,
		res_q.page_index, res_q.header_done, res_q.command_set, res_q.command_code};

endmodule

// File: bench/uart_bootloader_frame_parser_unit_tb.sv
`timescale 1ns / 100ps

module uart_bootloader_frame_parser_unit_tb;

	import ubfp_pkg::*;

	localparam int PAGE_BYTES = 1024;
	localparam int RANDOM_WORDS = 350;
	localparam int STUCK_LIMIT = 500;
	localparam logic [7:0] LINE_FEED = 8'h0A;

	// One serial word waiting to be sent, with an optional wait for the output to drain.
	typedef struct {
		logic [7:0] rx;
		logic phase;
		bit drain;
	} serial_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;  // rx_byte, program_phase
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;      // command_code, command_set, header_done,
	                                     // page_index, page_crc, prompt_seen, data_valid,
	                                     // data_index, data_value, page_done, page_length

	serial_word_t serial_words[$];
	ubfp_res_t expected_results[$];
	ubfp_res_t want;
	bit pause_next = 1'b0;
	bit calm = 1'b0;
	bit in_taken = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int stuck_cycles = 0;
	int errors = 0;
	int words_in = 0;
	int data_words = 0;
	int pages = 0;
	int command_writes = 0;
	int headers = 0;
	int prompts = 0;

	// Parser state as the block should hold it.
	logic [1:0] fw_seen = '0;
	logic [7:0] cmd_reg = CMD_NONE;
	logic [2:0] hdr_cnt = '0;
	logic [7:0] hdr_bytes [5] = '{default: 8'h00};
	logic [1:0] cmd_seen = '0;
	logic [1:0] gt_seen = '0;
	logic [3:0] recv_seen = '0;
	logic len_open = 1'b0;
	logic [2:0] len_chars = '0;
	logic [13:0] len_acc = '0;
	logic len_neg = 1'b0;
	logic len_halt = 1'b0;
	logic [10:0] page_target = '0;
	logic [2:0] lead_cnt = '0;
	logic [10:0] wr_ptr = '0;

	uart_bootloader_frame_parser_unit #(
		.PAGE_SIZE(PAGE_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	// Progress of the "+RECEIVE,1," tag after one more character.
	function automatic logic [3:0] receive_tag_step(input logic [3:0] m, input logic [7:0] b);
		logic [3:0] nxt;
		nxt = 4'd0;
		case (b)
			CH_PLUS: nxt = m + 4'd1;
			CH_R: nxt = (m == 4'd1) ? 4'd2 : 4'd0;
			CH_E: nxt = (m == 4'd2 || m == 4'd4 || m == 4'd7) ? m + 4'd1 : 4'd0;
			CH_C: nxt = (m == 4'd3) ? 4'd4 : 4'd0;
			CH_I: nxt = (m == 4'd5) ? 4'd6 : 4'd0;
			CH_V: nxt = (m == 4'd6) ? 4'd7 : 4'd0;
			CH_COMMA: nxt = (m == 4'd8 || m == 4'd10) ? m + 4'd1 : 4'd0;
			CH_ONE: nxt = (m == 4'd9) ? 4'd10 : 4'd0;
			default: nxt = 4'd0;
		endcase
		return nxt;
	endfunction

	// Runs all matchers on one serial word, in the block's order, and returns its result.
	function automatic ubfp_res_t parse_byte(input logic [7:0] b, input logic ph);
		ubfp_res_t r;
		r = '0;

		// Firmware command "$FW"; every extra dollar also counts up.
		if (b == CH_DOLLAR) fw_seen = fw_seen + 2'd1;
		else if (b == CH_F) fw_seen = (fw_seen == 2'd1) ? 2'd2 : 2'd0;
		else if (b == CH_W) fw_seen = (fw_seen == 2'd2) ? 2'd3 : 2'd0;
		else fw_seen = 2'd0;
		if (fw_seen == 2'd3) begin
			cmd_reg = CMD_FW;
			r.command_set = 1'b1;
			fw_seen = 2'd0;
		end

		// Header capture while the command is zero.
		if (cmd_reg == CMD_HEADER) begin
			if (hdr_cnt >= HDR_BYTES) hdr_cnt = 3'd0;
			hdr_bytes[hdr_cnt] = b;
			hdr_cnt = hdr_cnt + 3'd1;
			if (hdr_cnt == HDR_BYTES) begin
				cmd_reg = CMD_PAGE;
				r.command_set = 1'b1;
				r.header_done = 1'b1;
				hdr_cnt = 3'd0;
			end
		end

		// "$C" followed by the command byte.
		if (cmd_seen >= 2'd2) begin
			cmd_reg = b;
			r.command_set = 1'b1;
			cmd_seen = 2'd0;
		end
		if (b == CH_DOLLAR) cmd_seen = cmd_seen + 2'd1;
		else if (b == CH_C) cmd_seen = (cmd_seen == 2'd1) ? 2'd2 : 2'd0;
		else cmd_seen = 2'd0;

		// Send prompt "> ".
		if (b == CH_GT) gt_seen = gt_seen + 2'd1;
		else if (b == CH_SPACE) gt_seen = (gt_seen == 2'd1) ? 2'd2 : 2'd0;
		else gt_seen = 2'd0;
		if (gt_seen >= 2'd2) begin
			r.prompt_seen = 1'b1;
			gt_seen = 2'd0;
		end

		// Length field: up to four characters, closed by a colon or a fifth character.
		if (len_open) begin
			if (b != CH_COLON && len_chars < LEN_CHARS) begin
				if (len_chars == 3'd0 && b == CH_MINUS) len_neg = 1'b1;
				if (!len_halt) begin
					if (b == CH_NUL) len_halt = 1'b1;
					else if (b >= CH_ZERO && b <= CH_NINE)
						len_acc = len_acc * 14'd10 + {6'd0, b - CH_ZERO};
				end
				len_chars = len_chars + 3'd1;
			end else begin
				page_target = (len_neg || len_acc > PAGE_BYTES) ? 11'd0 : len_acc[10:0];
				len_open = 1'b0;
				len_chars = 3'd0;
				len_acc = 14'd0;
				len_neg = 1'b0;
				len_halt = 1'b0;
			end
		end

		// Page data: skip the lead-in, then write until the announced count is reached.
		if (page_target != 11'd0) begin
			if (lead_cnt >= LEAD_SKIP) begin
				if (wr_ptr < PAGE_BYTES) begin
					r.data_valid = 1'b1;
					r.data_index = wr_ptr[9:0];
					r.data_value = b;
					wr_ptr = wr_ptr + 11'd1;
				end
			end else begin
				lead_cnt = lead_cnt + 3'd1;
			end
			if (wr_ptr == page_target) begin
				r.page_done = 1'b1;
				r.page_length = wr_ptr;
				page_target = 11'd0;
				wr_ptr = 11'd0;
				lead_cnt = 3'd0;
			end
		end

		// The receive tag only advances in the program phase.
		if (ph) begin
			recv_seen = receive_tag_step(recv_seen, b);
			if (recv_seen >= RECV_FULL) begin
				len_open = 1'b1;
				recv_seen = 4'd0;
			end
		end

		r.command_code = cmd_reg;
		r.page_index = hdr_bytes[0];
		r.page_crc = {hdr_bytes[4], hdr_bytes[3], hdr_bytes[2], hdr_bytes[1]};
		return r;
	endfunction

	task automatic push_byte(input logic [7:0] rx, input logic ph);
		serial_words.push_back('{rx: rx, phase: ph, drain: pause_next});
		pause_next = 1'b0;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b1);
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++)
			push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// A line break resets the tag matcher, then the tag follows. A broken tag has
	// words outside the program phase wedged in, which the matcher must skip.
	task automatic push_tag(input bit broken);
		string tag;
		tag = "+RECEIVE,1,";
		push_byte(LINE_FEED, 1'b1);
		for (int i = 0; i < tag.len(); i++) begin
			push_byte(tag[i], 1'b1);
			if (broken && i < tag.len() - 1 && $urandom_range(0, 2) == 0) begin
				for (int j = $urandom_range(1, 2); j > 0; j--)
					push_byte(8'($urandom_range(0, 255)), 1'b0);
			end
		end
	endtask

	// Length text in one of several spellings that all give len.
	task automatic push_length(input int len, input int form);
		case (form)
			1: begin
				push_text($sformatf("%04d", len));
				push_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			2: push_text($sformatf(" %0d:", len));
			3: begin
				push_text($sformatf("%0d", len));
				push_byte(CH_NUL, 1'b1);
				push_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
				push_text(":");
			end
			default: push_text($sformatf("%0d:", len));
		endcase
	endtask

	// Complete page: tag, length, two more lead-in words, then len data words.
	task automatic push_page(input int len, input int form, input bit broken);
		push_tag(broken);
		push_length(len, form);
		push_random(2 + len);
	endtask

	// A second length arrives in the middle of a page. The new header is counted as
	// data, so the pointer stands at k + 15 after its colon and extra words finish it.
	task automatic push_page_retarget();
		int k;
		int extra;
		k = $urandom_range(0, 5);
		extra = $urandom_range(0, 10);
		push_tag(1'b0);
		push_text($sformatf("%0d:", $urandom_range(30, 60)));
		push_random(2 + k);
		push_tag(1'b0);
		push_text($sformatf("%0d:", k + 15 + extra));
		push_random(extra);
	endtask

	// Length fields that must not start a page.
	task automatic push_bad_length();
		push_tag(1'b0);
		case ($urandom_range(0, 4))
			0: push_text($sformatf("-%0d:", $urandom_range(1, 99)));
			1: push_text($sformatf("%0d:", $urandom_range(PAGE_BYTES + 1, 9999)));
			2: push_text("0:");
			3: begin
				push_byte(CH_NUL, 1'b1);
				push_text("5:");
			end
			default: push_text("ab:");
		endcase
	endtask

	task automatic push_command();
		case ($urandom_range(0, 7))
			0: push_text("$FW");
			1: push_text("$$W");
			2: begin
				push_text("$C");
				push_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			3: begin
				push_text("$$");
				push_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			4: begin
				push_text("$C");
				push_byte(CMD_HEADER, 1'b1);
				push_random(5);
			end
			5: push_text("> ");
			6: push_text(">>");
			default: push_text("$FX");
		endcase
	endtask

	// Sender: presents the next word at the falling edge, with random gaps.
	always @(negedge clk) begin
		calm <= (serial_words.size() < 120);
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (serial_words.size() != 0 &&
					(!serial_words[0].drain || expected_results.size() == 0)) begin
				s_tvalid <= 1'b1;
				s_tdata <= {7'd0, serial_words[0].phase, serial_words[0].rx};
				void'(serial_words.pop_front());
				if (!calm && $urandom_range(0, 6) == 0) gap_left <= $urandom_range(1, 4);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: ready with random stall bursts.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!calm && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 4);
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Monitor: checks each result word, predicts each accepted word, and watches for hangs.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result word 0x%0h arrived with nothing expected", m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("command_code", want.command_code, m_tdata[7:0]);
					check_field("command_set", want.command_set, m_tdata[8]);
					check_field("header_done", want.header_done, m_tdata[9]);
					check_field("page_index", want.page_index, m_tdata[17:10]);
					check_field("page_crc", want.page_crc, m_tdata[49:18]);
					check_field("prompt_seen", want.prompt_seen, m_tdata[50]);
					check_field("data_valid", want.data_valid, m_tdata[51]);
					check_field("data_index", want.data_index, m_tdata[61:52]);
					check_field("data_value", want.data_value, m_tdata[69:62]);
					check_field("page_done", want.page_done, m_tdata[70]);
					check_field("page_length", want.page_length, m_tdata[81:71]);
				end
			end
			if (s_tvalid && s_tready) begin
				want = parse_byte(s_tdata[7:0], s_tdata[8]);
				expected_results.push_back(want);
				words_in++;
				data_words += want.data_valid;
				pages += want.page_done;
				command_writes += want.command_set;
				headers += want.header_done;
				prompts += want.prompt_seen;
			end
			in_taken <= s_tvalid && s_tready;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("No word moved for %0d cycles.", STUCK_LIMIT);
				$display("simulation failed");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	initial begin
		int first_random;
		int pick;

		// Field extremes with both phase values.
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);

		// Commands, repeated leaders, header capture and prompts.
		push_text("$FW");
		push_text("$$W");
		push_text("$$$");
		push_text("$C");
		push_byte(8'hFF, 1'b1);
		push_text("$$");
		push_byte(8'h7E, 1'b1);
		push_text("$C");
		push_byte(CMD_HEADER, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b1);
		push_byte(8'h80, 1'b1);
		push_byte(8'h01, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_text("> ");
		push_text(">>");

		// A short page, lengths that start none, and a tag split by other-phase words.
		push_page(3, 0, 1'b0);
		push_tag(1'b0);
		push_text("-3:");
		push_tag(1'b0);
		push_text("1025:");
		push_tag(1'b0);
		push_text("0:");
		push_tag(1'b0);
		push_byte(CH_NUL, 1'b1);
		push_text("7:");
		push_page(2, 3, 1'b1);

		// Zero length in mid-page keeps the counters; a smaller length later lets the
		// pointer run past it, and a larger length after that finishes the page.
		pause_next = 1'b1;
		push_tag(1'b0);
		push_text("1000:");
		push_random(2 + 5);
		push_tag(1'b0);
		push_text("0:");
		push_tag(1'b0);
		push_text("900:");
		push_random(10);
		push_tag(1'b0);
		push_text("5:");
		push_random(10);
		push_tag(1'b0);
		push_text("80:");
		push_random(12);

		// Random traffic, mostly well-formed frames with random content.
		first_random = serial_words.size();
		while (serial_words.size() - first_random < RANDOM_WORDS) begin
			if ($urandom_range(0, 29) == 0) pause_next = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				push_page(($urandom_range(0, 9) == 0) ? $urandom_range(25, 99) :
					$urandom_range(1, 24), $urandom_range(0, 3), 1'b0);
			end else if (pick < 45) begin
				push_page_retarget();
			end else if (pick < 55) begin
				push_bad_length();
			end else if (pick < 75) begin
				push_command();
			end else if (pick < 85) begin
				push_page($urandom_range(1, 12), $urandom_range(0, 3), 1'b1);
			end else begin
				push_random($urandom_range(1, 8));
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (serial_words.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Parsed %0d serial words; %0d page data writes over %0d completed pages.",
			words_in, data_words, pages);
		$display("Command register written %0d times, %0d headers taken, %0d prompts seen.",
			command_writes, headers, prompts);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/ubfp_pkg.sv
hw/rtl/ubfp_parser.sv
hw/rtl/uart_bootloader_frame_parser_unit.sv
bench/uart_bootloader_frame_parser_unit_tb.sv
